### hw/rtl/rpc_record_mark_deframer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the record-mark deframer
// Shared concurrent assertion forms, clocked and disabled by reset.
// ----------------------------------------------------------------------------
`ifndef RPC_RECORD_MARK_DEFRAMER_CORE_MACROS_SVH
`define RPC_RECORD_MARK_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication.
`define RPCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("rpcd assertion failed");

// Next-cycle implication.
`define RPCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("rpcd assertion failed");

`endif

### hw/rtl/rpcd_pkg.sv
// ----------------------------------------------------------------------------
// rpcd_pkg
// Types and constants shared by the record-mark deframer modules.
// ----------------------------------------------------------------------------
package rpcd_pkg;

	localparam int unsigned MaxWidth  = 25;
	localparam int unsigned DeclWidth = 32;
	localparam int unsigned LenWidth  = 31;

	localparam logic [MaxWidth-1:0] MAX_RESET = 25'd65536;
	localparam logic [DeclWidth-1:0] DECL_SAT = 32'hffff_ffff;

	typedef enum logic [1:0] {
		KIND_MARKER  = 2'd0,
		KIND_KEPT    = 2'd1,
		KIND_DROPPED = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [7:0]           data;
		logic                 message_end;
		logic                 too_long;
		logic [MaxWidth-1:0]  kept_count;
		logic [DeclWidth-1:0] declared_length;
	} result_t;

endpackage

### hw/rtl/rpcd_in_stage.sv
// ----------------------------------------------------------------------------
// rpcd_in_stage
// Input register: captures one stream byte per beat and holds it until used.
// ----------------------------------------------------------------------------
module rpcd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic accept;

	// stall only while a held byte cannot move on this cycle
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
		end
	end

endmodule

### hw/rtl/rpcd_engine.sv
// ----------------------------------------------------------------------------
// rpcd_engine
// Deframing state and the per-byte update: marker gather, length tally, limit.
// ----------------------------------------------------------------------------
`include "rpc_record_mark_deframer_core_macros.svh"

module rpcd_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step_en,
	input  logic [7:0]                      byte_in,
	input  logic [rpcd_pkg::MaxWidth-1:0]   max_bytes,
	output rpcd_pkg::result_t               res
);

	typedef enum logic [3:0] {
		PH_MESSAGE = 4'b0001,
		PH_MARKER  = 4'b0010,
		PH_DATA    = 4'b0100,
		PH_LAST    = 4'b1000
	} phase_t;

	phase_t                             phase_q, phase_d;
	logic [1:0]                         seen_q, seen_d;
	logic [31:0]                        shift_q, shift_d;
	logic [rpcd_pkg::LenWidth-1:0]      rem_q, rem_d;
	logic [rpcd_pkg::DeclWidth-1:0]     decl_q, decl_d;
	logic [rpcd_pkg::MaxWidth-1:0]      kept_q, kept_d;
	logic                               over_q, over_d;

	// values at the start of this byte, after a new message clears them
	phase_t                             ph_e;
	logic [1:0]                         seen_e;
	logic [31:0]                        shift_e;
	logic [rpcd_pkg::DeclWidth-1:0]     decl_e;
	logic [rpcd_pkg::MaxWidth-1:0]      kept_e;
	logic                               over_e;

	logic [31:0]                        shift_n;
	logic [rpcd_pkg::DeclWidth:0]       sum;
	logic [rpcd_pkg::LenWidth-1:0]      flen;
	logic [rpcd_pkg::LenWidth-1:0]      rem_dec;
	rpcd_pkg::kind_t                    kind;
	logic                               end_flag;

	always_comb begin
		if (phase_q == PH_MESSAGE) begin
			ph_e    = PH_MARKER;
			seen_e  = 2'd0;
			shift_e = 32'd0;
			decl_e  = '0;
			kept_e  = '0;
			over_e  = 1'b0;
		end else begin
			ph_e    = phase_q;
			seen_e  = seen_q;
			shift_e = shift_q;
			decl_e  = decl_q;
			kept_e  = kept_q;
			over_e  = over_q;
		end
	end

	assign shift_n = {shift_e[23:0], byte_in};
	assign flen    = shift_n[rpcd_pkg::LenWidth-1:0];
	assign sum     = {1'b0, decl_e} + {2'b00, flen};
	assign rem_dec = rem_q - 1'b1;

	always_comb begin
		phase_d  = ph_e;
		seen_d   = seen_e;
		shift_d  = shift_e;
		rem_d    = rem_q;
		decl_d   = decl_e;
		kept_d   = kept_e;
		over_d   = over_e;
		kind     = rpcd_pkg::KIND_MARKER;
		end_flag = 1'b0;
		case (ph_e)
			PH_MARKER: begin
				if (seen_e == 2'd3) begin
					seen_d  = 2'd0;
					shift_d = 32'd0;
					decl_d  = sum[rpcd_pkg::DeclWidth] ? rpcd_pkg::DECL_SAT
						: sum[rpcd_pkg::DeclWidth-1:0];
					if (decl_d > {{(rpcd_pkg::DeclWidth-rpcd_pkg::MaxWidth){1'b0}},
						max_bytes}) begin
						over_d = 1'b1;
					end
					if (flen == '0) begin
						if (shift_n[31]) begin
							end_flag = 1'b1;
							phase_d  = PH_MESSAGE;
						end else begin
							phase_d = PH_MARKER;
						end
					end else begin
						rem_d   = flen;
						phase_d = shift_n[31] ? PH_LAST : PH_DATA;
					end
				end else begin
					seen_d  = seen_e + 2'd1;
					shift_d = shift_n;
				end
			end
			PH_DATA, PH_LAST: begin
				if (kept_e < max_bytes) begin
					kind   = rpcd_pkg::KIND_KEPT;
					kept_d = kept_e + 1'b1;
				end else begin
					kind = rpcd_pkg::KIND_DROPPED;
				end
				rem_d = rem_dec;
				if (rem_dec == '0) begin
					if (ph_e == PH_LAST) begin
						end_flag = 1'b1;
						phase_d  = PH_MESSAGE;
					end else begin
						phase_d = PH_MARKER;
						seen_d  = 2'd0;
						shift_d = 32'd0;
					end
				end
			end
			default: begin
				phase_d = PH_MESSAGE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MESSAGE;
			seen_q  <= 2'd0;
			shift_q <= 32'd0;
			rem_q   <= '0;
			decl_q  <= '0;
			kept_q  <= '0;
			over_q  <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			seen_q  <= seen_d;
			shift_q <= shift_d;
			rem_q   <= rem_d;
			decl_q  <= decl_d;
			kept_q  <= kept_d;
			over_q  <= over_d;
		end
	end

	assign res.kind            = kind;
	assign res.data            = byte_in;
	assign res.message_end     = end_flag;
	assign res.too_long        = over_d;
	assign res.kept_count      = kept_d;
	assign res.declared_length = decl_d;

	`RPCD_ASSERT_IMP(a_rem_nonzero_in_data, clk, arst_n,
		(phase_q == PH_DATA || phase_q == PH_LAST), rem_q != '0)
	`RPCD_ASSERT_IMP(a_seen_only_in_marker, clk, arst_n,
		seen_q != 2'd0, phase_q == PH_MARKER)
	`RPCD_ASSERT_IMP(a_kept_within_declared, clk, arst_n,
		1'b1, {{(rpcd_pkg::DeclWidth-rpcd_pkg::MaxWidth){1'b0}}, kept_q} <= decl_q)
	`RPCD_ASSERT_NXT(a_end_restarts_message, clk, arst_n,
		step_en && end_flag, phase_q == PH_MESSAGE)

endmodule

### hw/rtl/rpc_record_mark_deframer_core.sv
// ----------------------------------------------------------------------------
// rpc_record_mark_deframer_core
// Record-mark deframer for an RPC-over-TCP byte stream.
// ----------------------------------------------------------------------------
// Use:
//   Feed the reassembled stream one byte per beat on in_valid/data_byte;
//   the block raises in_stall when it cannot take a beat. Each input beat
//   yields exactly one output beat on out_valid with kind (marker, kept or
//   dropped payload), the byte copy, message_end, too_long, kept_count and
//   declared_length; the last three show the state after that byte.
//   max_message_bytes is written through cfg_wr_en/cfg_wr_data; write it
//   only while no beat is in flight.
// Timing:
//   The byte sits in the input register, then the state update writes the
//   result register when the byte advances; the result beat is offered
//   from there. One beat per cycle is sustained while out_stall is low; the
//   state update is a single 33-bit add with saturation and a 32-bit
//   compare per byte.
// Reset:
//   arst_n clears both pipeline valid bits and the deframing state; the
//   limit returns to 65536 bytes.
// Stall:
//   out_stall holds the result register; the input register still fills,
//   then in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module rpc_record_mark_deframer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      data_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      kind,
	output logic [7:0]                      data_out,
	output logic                            message_end,
	output logic                            too_long,
	output logic [rpcd_pkg::MaxWidth-1:0]   kept_count,
	output logic [rpcd_pkg::DeclWidth-1:0]  declared_length,
	input  logic                            cfg_wr_en,
	input  logic [rpcd_pkg::MaxWidth-1:0]   cfg_wr_data
);

	logic [rpcd_pkg::MaxWidth-1:0] max_bytes_q;
	logic                          valid_s1;
	logic [7:0]                    byte_s1;
	logic                          valid_s2;
	logic                          s2_free;
	logic                          advance;
	rpcd_pkg::result_t             res;
	rpcd_pkg::result_t             res_s2;

	// limit register: takes effect on the next byte processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= rpcd_pkg::MAX_RESET;
		end else if (cfg_wr_en) begin
			max_bytes_q <= cfg_wr_data;
		end
	end

	// result slot frees when empty or being drained this cycle
	assign s2_free = !valid_s2 || !out_stall;
	assign advance = valid_s1 && s2_free;

	rpcd_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1)
	);

	// update the deframing state only when the byte moves into the result slot
	rpcd_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.byte_in   (byte_s1),
		.max_bytes (max_bytes_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	// hold the result while the receiver stalls
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign kind            = res_s2.kind;
	assign data_out        = res_s2.data;
	assign message_end     = res_s2.message_end;
	assign too_long        = res_s2.too_long;
	assign kept_count      = res_s2.kept_count;
	assign declared_length = res_s2.declared_length;

endmodule

### verif/rpcd_deframe_checker.sv
// ----------------------------------------------------------------------------
// rpcd_deframe_checker
// Watches both beat channels and the limit port of the record-mark deframer.
// Predicts one result per accepted input byte and compares, in order, every
// accepted output beat against it field by field.
// ----------------------------------------------------------------------------
module rpcd_deframe_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [7:0]                     data_byte,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [1:0]                     kind,
	input  logic [7:0]                     data_out,
	input  logic                           message_end,
	input  logic                           too_long,
	input  logic [rpcd_pkg::MaxWidth-1:0]  kept_count,
	input  logic [rpcd_pkg::DeclWidth-1:0] declared_length,
	input  logic                           cfg_wr_en,
	input  logic [rpcd_pkg::MaxWidth-1:0]  cfg_wr_data,
	output int                             mismatch_count,
	output int                             results_outstanding
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_MARKER = 4'b0010,
		ST_DATA   = 4'b0100,
		ST_LAST   = 4'b1000
	} deframe_state_t;

	logic [rpcd_pkg::MaxWidth-1:0]  limit;
	deframe_state_t                 state;
	logic [1:0]                     hdr_count;
	logic [31:0]                    hdr_shift;
	logic [rpcd_pkg::LenWidth-1:0]  frag_left;
	logic [rpcd_pkg::DeclWidth-1:0] decl_total;
	logic [rpcd_pkg::MaxWidth-1:0]  kept_total;
	logic                           over_limit;
	rpcd_pkg::result_t              predicted_results[$];

	// Advance the deframing state by one stream byte and return its result.
	function automatic rpcd_pkg::result_t deframe_byte(input logic [7:0] b);
		rpcd_pkg::result_t             r;
		logic [rpcd_pkg::DeclWidth:0]  sum;
		logic [rpcd_pkg::LenWidth-1:0] flen;
		logic                          last;
		r.kind = rpcd_pkg::KIND_MARKER;
		r.message_end = 1'b0;
		if (state == ST_IDLE) begin
			decl_total = '0;
			kept_total = '0;
			over_limit = 1'b0;
			hdr_count = '0;
			hdr_shift = '0;
			state = ST_MARKER;
		end
		if (state == ST_MARKER) begin
			hdr_shift = {hdr_shift[23:0], b};
			if (hdr_count == 2'd3) begin
				last = hdr_shift[31];
				flen = hdr_shift[rpcd_pkg::LenWidth-1:0];
				sum = {1'b0, decl_total} + {2'b00, flen};
				decl_total = sum[rpcd_pkg::DeclWidth] ? rpcd_pkg::DECL_SAT
					: sum[rpcd_pkg::DeclWidth-1:0];
				if (decl_total > {7'd0, limit})
					over_limit = 1'b1;
				hdr_count = '0;
				hdr_shift = '0;
				if (flen == '0) begin
					if (last) begin
						r.message_end = 1'b1;
						state = ST_IDLE;
					end
				end else begin
					frag_left = flen;
					if (last)
						state = ST_LAST;
					else
						state = ST_DATA;
				end
			end else begin
				hdr_count = hdr_count + 2'd1;
			end
		end else begin
			if (kept_total < limit) begin
				r.kind = rpcd_pkg::KIND_KEPT;
				kept_total = kept_total + 1'b1;
			end else begin
				r.kind = rpcd_pkg::KIND_DROPPED;
			end
			frag_left = frag_left - 1'b1;
			if (frag_left == '0) begin
				if (state == ST_LAST) begin
					r.message_end = 1'b1;
					state = ST_IDLE;
				end else begin
					state = ST_MARKER;
					hdr_count = '0;
					hdr_shift = '0;
				end
			end
		end
		r.data = b;
		r.too_long = over_limit;
		r.kept_count = kept_total;
		r.declared_length = decl_total;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rpcd_pkg::result_t want;
		rpcd_pkg::result_t next_r;
		if (!arst_n) begin
			limit = rpcd_pkg::MAX_RESET;
			state = ST_IDLE;
			hdr_count = '0;
			hdr_shift = '0;
			frag_left = '0;
			decl_total = '0;
			kept_total = '0;
			over_limit = 1'b0;
			predicted_results.delete();
			mismatch_count = 0;
			results_outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					$display("%0t result beat with none expected: data %0h kind %0d",
						$time, data_out, kind);
					mismatch_count++;
				end else begin
					want = predicted_results.pop_front();
					check_field("kind", 32'(want.kind), 32'(kind));
					check_field("data_out", 32'(want.data), 32'(data_out));
					check_field("message_end", 32'(want.message_end), 32'(message_end));
					check_field("too_long", 32'(want.too_long), 32'(too_long));
					check_field("kept_count", 32'(want.kept_count), 32'(kept_count));
					check_field("declared_length", want.declared_length, declared_length);
				end
			end
			if (cfg_wr_en)
				limit = cfg_wr_data;
			if (in_valid && !in_stall) begin
				next_r = deframe_byte(data_byte);
				predicted_results = {predicted_results, next_r};
			end
			results_outstanding <= predicted_results.size();
		end
	end

endmodule

### verif/tb_rpc_record_mark_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_rpc_record_mark_deframer_core
// Stream-level test of the record-mark deframer: directed marker cases, then
// random multi-fragment messages under a series of byte limits, with random
// stalls on both channels; results are checked by rpcd_deframe_checker.
// ----------------------------------------------------------------------------
module tb_rpc_record_mark_deframer_core;

	logic                           clk;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [7:0]                     data_byte = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [1:0]                     kind;
	logic [7:0]                     data_out;
	logic                           message_end;
	logic                           too_long;
	logic [rpcd_pkg::MaxWidth-1:0]  kept_count;
	logic [rpcd_pkg::DeclWidth-1:0] declared_length;
	logic                           cfg_wr_en = 1'b0;
	logic [rpcd_pkg::MaxWidth-1:0]  cfg_wr_data = '0;

	int mismatch_count;
	int results_outstanding;

	// Idling controls, changed per phase by the stimulus process.
	bit tx_gaps = 1'b0;
	bit rx_gaps = 1'b0;
	int hold_cycles = 0;

	// Stream bytes built but not yet sent; a phase may end mid-message.
	logic [7:0] stream_q[$];
	int bytes_sent = 0;
	int messages_built = 0;
	int limits_written = 0;

	rpc_record_mark_deframer_core u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.data_out        (data_out),
		.message_end     (message_end),
		.too_long        (too_long),
		.kept_count      (kept_count),
		.declared_length (declared_length),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data)
	);

	rpcd_deframe_checker u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.data_byte           (data_byte),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.kind                (kind),
		.data_out            (data_out),
		.message_end         (message_end),
		.too_long            (too_long),
		.kept_count          (kept_count),
		.declared_length     (declared_length),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_wr_data         (cfg_wr_data),
		.mismatch_count      (mismatch_count),
		.results_outstanding (results_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: far beyond the slowest legal run with every stall maxed out.
	initial begin
		#2000000;
		$display("tb_rpc_record_mark_deframer_core: errors");
		$finish;
	end

	// Receiver: long hold-off on request, otherwise random stall bursts.
	initial begin
		forever begin
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// Offer one byte and hold it until the block takes the beat. Valid stays
	// high between back-to-back beats; a gap drops it for a random burst.
	task automatic send_byte(input logic [7:0] b);
		if (tx_gaps && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	// Append one message: one to four fragments, the final one flagged last.
	// Lengths are mostly short, sometimes zero, sometimes a few hundred.
	task automatic build_message();
		int          nfrag;
		int unsigned sel;
		logic [31:0] marker;
		nfrag = $urandom_range(1, 4);
		for (int f = 0; f < nfrag; f++) begin
			sel = $urandom_range(0, 19);
			marker = '0;
			if (sel >= 17)
				marker[30:0] = 31'($urandom_range(25, 300));
			else if (sel >= 3)
				marker[30:0] = 31'($urandom_range(1, 24));
			marker[31] = (f == nfrag - 1);
			for (int k = 3; k >= 0; k--)
				stream_q = {stream_q, marker[k*8 +: 8]};
			for (int k = 0; k < marker[30:0]; k++)
				stream_q = {stream_q, 8'($urandom)};
		end
		messages_built++;
	endtask

	// Send n stream bytes, building messages as the queue runs dry.
	task automatic send_stream(input int n);
		for (int k = 0; k < n; k++) begin
			if (stream_q.size() == 0)
				build_message();
			send_byte(stream_q.pop_front());
		end
	endtask

	// Drop valid and hold until every predicted result has been taken.
	// The outstanding count is registered, so let it update before trusting it.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_outstanding != 0) @(posedge clk);
	endtask

	task automatic write_limit(input logic [rpcd_pkg::MaxWidth-1:0] value);
		cfg_wr_data <= value;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limits_written++;
	endtask

	initial begin
		logic [7:0]                    directed[$];
		logic [rpcd_pkg::MaxWidth-1:0] limit_plan[6];
		logic [rpcd_pkg::MaxWidth-1:0] lim;
		int                            phase_no;
		int                            random_sent;

		limit_plan = '{25'd1, 25'd0, 25'd16777216, 25'd3, 25'd16777215, 25'd12};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, at the reset limit:
		//   zero-length last fragment ends the message on the marker itself;
		//   zero-length non-last fragment is followed straight by a two-byte last one;
		//   a one-byte fragment of all ones, then an empty last fragment.
		directed = '{8'h80, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h02, 8'hAA, 8'h55,
			8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00};
		foreach (directed[k])
			send_byte(directed[k]);
		drain();

		// Random phases. Each one waits for the block to go idle, writes a new
		// limit and sends a slice of the stream; slices cut messages at random
		// points, so the limit often changes mid-message.
		phase_no = 0;
		random_sent = 0;
		while (random_sent < 1450) begin
			drain();
			if (phase_no < 6)
				lim = limit_plan[phase_no];
			else if ($urandom_range(0, 1) == 0)
				lim = 25'($urandom_range(1, 40));
			else
				lim = 25'($urandom_range(41, 16777216));
			write_limit(lim);
			tx_gaps = ($urandom_range(0, 2) != 0);
			rx_gaps = ($urandom_range(0, 2) != 0);
			if (phase_no == 2) begin
				// Hold the receiver off while the sender keeps pushing beats,
				// so the pipeline fills and backs up into in_stall.
				tx_gaps = 1'b0;
				hold_cycles = 80;
			end
			begin
				int n;
				n = $urandom_range(90, 180);
				send_stream(n);
				random_sent += n;
			end
			phase_no++;
		end

		// Final stretch, no idling on either side: finish the open message,
		// then open a last fragment of maximum length and send part of it.
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		drain();
		write_limit(25'($urandom_range(1, 40)));
		while (stream_q.size() != 0)
			send_byte(stream_q.pop_front());
		repeat (4) send_byte(8'hFF);
		repeat (40) send_byte(8'($urandom));

		drain();
		repeat (8) @(posedge clk);

		$display("Sent %0d stream bytes (%0d random messages) under %0d limit writes,",
			bytes_sent, messages_built, limits_written);
		$display("limits 0, 1, small, 2**24-1 and 2**24, with mid-message changes and stalls.");
		if (mismatch_count == 0 && results_outstanding == 0)
			$display("tb_rpc_record_mark_deframer_core: clean");
		else
			$display("tb_rpc_record_mark_deframer_core: errors");
		$finish;
	end

endmodule
